[rtl/rpn_pkg.sv]
`timescale 1ns / 1ps
package rpn_pkg;
    localparam int STACK_DEPTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VAL_W             = 64;

    typedef enum logic [1:0] {
        REQ_NUMBER = 2'd0,
        REQ_OPER   = 2'd1,
        REQ_END    = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [30:0] number_value;
        logic [1:0]  operator_code;
    } t_in;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         status;
    } t_out;

    // stack cell row control: push shifts everything down, pop shifts up
    typedef struct packed {
        logic              push;
        logic              pop2;   // replace two tops with one value
        logic [VAL_W-1:0]  data;
    } t_cell_ctl;

    localparam logic [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic [VAL_W-1:0] sat_addsub(input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b,
                                                    input logic sub);
        logic [VAL_W-1:0] bb;
        logic [VAL_W-1:0] s;
        bb = sub ? ~b : b;
        s  = a + bb + {{(VAL_W-1){1'b0}}, sub};
        if (a[VAL_W-1] == bb[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
            return a[VAL_W-1] ? SMIN : SMAX;
        return s;
    endfunction
endpackage

[rtl/rpn_cell.sv]
`timescale 1ns / 1ps
// One stack entry; takes its value from the neighbor above (push) or below (pop).
module rpn_cell
    import rpn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_push,
    input  logic             i_pop,
    input  logic [VAL_W-1:0] i_from_up,
    input  logic [VAL_W-1:0] i_from_down,
    output logic [VAL_W-1:0] o_value
);
    logic [VAL_W-1:0] r_value;
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_value <= i_from_up;
        else if (i_pop)
            r_value <= i_from_down;
    end
    assign o_value = r_value;
endmodule

[rtl/rpn_stack.sv]
`timescale 1ns / 1ps
// Row of cells; cell 0 is top of stack. pop2 writes data to cell 0, moves rest up by one.
module rpn_stack
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    output logic [VAL_W-1:0] o_top0,
    output logic [VAL_W-1:0] o_top1,
    output logic [VAL_W-1:0] o_bottom_sel,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] i_count
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    logic [VAL_W-1:0] w_val [STACK_DEPTH];
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_up, w_down;
        logic             w_pop;
        if (g == 0) begin : g_top
            assign w_up   = i_ctl.data;
            assign w_down = i_ctl.data;
            assign w_pop  = i_ctl.pop2;
        end else begin : g_mid
            assign w_up   = w_val[g-1];
            assign w_down = (g + 1 < STACK_DEPTH) ? w_val[(g + 1) % STACK_DEPTH] : w_val[g];
            assign w_pop  = i_ctl.pop2;
        end
        rpn_cell u_cell (
            .i_clk      (i_clk),
            .i_push     (i_ctl.push),
            .i_pop      (w_pop),
            .i_from_up  (w_up),
            .i_from_down(w_down),
            .o_value    (w_val[g])
        );
    end
    assign o_top0 = w_val[0];
    assign o_top1 = w_val[1];
    // with exactly one value stacked, the top cell is the bottom value
    assign o_bottom_sel = (i_count == CW'(1)) ? w_val[0] : '0;
endmodule

[rtl/rpn_muldiv.sv]
`timescale 1ns / 1ps
// Magnitude multiply (4 x 32x32 partials, one per cycle) and restoring divide (1 bit/cycle).
module rpn_muldiv
    import rpn_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_div,
    input  logic [VAL_W-1:0] i_l,
    input  logic [VAL_W-1:0] i_r,
    output logic             o_done,
    output logic [VAL_W-1:0] o_result
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;
    t_state r_state;
    logic [6:0]   r_cnt;
    logic         r_neg;
    logic [63:0]  r_x, r_d, r_rem;
    logic [127:0] r_acc, r_n;
    logic [63:0]  r_prod;
    logic         r_done;
    logic [VAL_W-1:0] r_result;

    logic [63:0] w_ma, w_mb;
    assign w_ma = i_l[63] ? (64'd0 - i_l) : i_l;
    assign w_mb = i_r[63] ? (64'd0 - i_r) : i_r;

    logic [31:0] w_pa, w_pb;
    assign w_pa = r_cnt[1] ? r_x[63:32] : r_x[31:0];
    assign w_pb = r_cnt[0] ? r_d[63:32] : r_d[31:0];

    // r_prod holds the partial picked in the previous cycle: shifts 0, 32, 32, 64
    logic [6:0] w_pc;
    logic [6:0] w_psh;
    assign w_pc  = r_cnt - 7'd1;
    assign w_psh = {w_pc[1] & w_pc[0], w_pc[1] ^ w_pc[0], 5'd0};

    logic [64:0] w_trial;
    logic [64:0] w_rsh;
    assign w_rsh   = {r_rem, r_n[127]};
    assign w_trial = w_rsh - {1'b0, r_d};

    logic [127:0] w_mag;
    logic [127:0] w_sh;
    assign w_sh  = r_acc >> FRACTION_BITS;
    assign w_mag = w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_x   <= w_ma;
                    r_d   <= w_mb;
                    r_neg <= i_l[63] ^ i_r[63];
                    r_cnt <= '0;
                    r_acc <= '0;
                    r_rem <= '0;
                    r_n   <= {64'd0, w_ma} << FRACTION_BITS;
                    r_state <= i_div ? S_DIV : S_MUL;
                end
                S_MUL: begin
                    // product registered, accumulate next cycle
                    r_prod <= w_pa * w_pb;
                    if (r_cnt != 7'd0)
                        r_acc <= r_acc + ({64'd0, r_prod} << w_psh);
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd4) r_state <= S_FIN;
                end
                S_DIV: begin
                    r_n <= r_n << 1;
                    // last bit: pre-shift so the common fraction shift in S_FIN cancels
                    r_acc <= (r_cnt == 7'd127) ?
                             ({r_acc[126:0], ~w_trial[64]} << FRACTION_BITS) :
                             {r_acc[126:0], ~w_trial[64]};
                    r_rem <= w_trial[64] ? w_rsh[63:0] : w_trial[63:0];
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (!r_neg)
                        r_result <= (w_mag[127:63] != 0) ? SMAX : w_mag[63:0];
                    else
                        r_result <= (w_mag[127:64] != 0 || (w_mag[63] && w_mag[62:0] != 0))
                                    ? SMIN : (64'd0 - w_mag[63:0]);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_done   = r_done;
    assign o_result = r_result;
endmodule

[rtl/rpn_stack_evaluator.sv]
`timescale 1ns / 1ps
// Channel | Ports                      | Payload
// in      | i_in_valid / o_in_ready    | t_in  (req_type, number_value, operator_code)
// out     | o_out_valid / i_out_ready  | t_out (result_value, status)
// Number, add, subtract and end are handled directly; multiply sums four 32x32 partials.
// Divide: one quotient bit per cycle over 128 bits.
// Reset clears stack count and error; stack cells hold unwritten data until pushed.
// An end token waits while a previous result is still held in the output register.
module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    typedef enum logic {S_RUN, S_WAIT} t_state;
    t_state r_state;
    logic [CW-1:0] r_count;
    logic [1:0]    r_err;
    logic          r_ov;
    t_out          r_out;
    t_cell_ctl     w_ctl;
    logic [VAL_W-1:0] w_t0, w_t1, w_bot, w_md;
    logic w_done, w_start, w_acc, w_opok;

    rpn_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_ctl(w_ctl), .o_top0(w_t0), .o_top1(w_t1),
        .o_bottom_sel(w_bot), .i_count(r_count));
    rpn_muldiv #(.FRACTION_BITS(FRACTION_BITS)) u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_div(i_in.operator_code == OP_DIV), .i_l(w_t1), .i_r(w_t0),
        .o_done(w_done), .o_result(w_md));

    assign o_in_ready = (r_state == S_RUN) && !(i_in.req_type == REQ_END && r_ov);
    assign w_acc = i_in_valid && o_in_ready;
    assign w_opok = (r_err == ST_OK) && r_count >= CW'(2);
    assign w_start = w_acc && i_in.req_type == REQ_OPER && w_opok &&
                     (i_in.operator_code == OP_MUL ||
                      (i_in.operator_code == OP_DIV && w_t0 != 0));

    always_comb begin
        w_ctl = '0;
        if (r_state == S_WAIT && w_done) begin
            w_ctl.pop2 = 1'b1;
            w_ctl.data = w_md;
        end else if (w_acc && r_err == ST_OK) begin
            if (i_in.req_type == REQ_NUMBER && r_count < CW'(STACK_DEPTH)) begin
                w_ctl.push = 1'b1;
                w_ctl.data = VAL_W'({33'd0, i_in.number_value} << FRACTION_BITS);
            end else if (i_in.req_type == REQ_OPER && w_opok &&
                         (i_in.operator_code == OP_ADD || i_in.operator_code == OP_SUB)) begin
                w_ctl.pop2 = 1'b1;
                w_ctl.data = sat_addsub(w_t1, w_t0, i_in.operator_code == OP_SUB);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_count <= '0;
            r_err   <= ST_OK;
            r_ov    <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) r_ov <= 1'b0;
            if (r_state == S_WAIT) begin
                if (w_done) begin
                    r_state <= S_RUN;
                    r_count <= r_count - CW'(1);
                end
            end else if (w_acc) begin
                case (i_in.req_type)
                    REQ_NUMBER: if (r_err == ST_OK) begin
                        if (r_count < CW'(STACK_DEPTH)) r_count <= r_count + CW'(1);
                        else r_err <= ST_OVERFLOW;
                    end
                    REQ_OPER: if (r_err == ST_OK) begin
                        if (!w_opok) r_err <= ST_INVALID;
                        else if (i_in.operator_code == OP_DIV && w_t0 == 0) r_err <= ST_DIVZERO;
                        else if (w_start) r_state <= S_WAIT;
                        else r_count <= r_count - CW'(1);
                    end
                    REQ_END: begin
                        r_ov <= 1'b1;
                        if (r_err == ST_OK && r_count == CW'(1)) begin
                            r_out.result_value <= w_bot;
                            r_out.status       <= ST_OK;
                        end else begin
                            r_out.result_value <= '0;
                            r_out.status       <= (r_err == ST_OK) ? ST_INVALID : r_err;
                        end
                        r_count <= '0;
                        r_err   <= ST_OK;
                    end
                    default: ;
                endcase
            end
        end
    end
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
endmodule

[rtl/rpn_checker.sv]
`timescale 1ns / 1ps
module rpn_checker
    import rpn_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out)) else $error("out held");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.result_value == 0) else $error("err val");
    a_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && o_in_ready && i_in.req_type == REQ_END)
        |=> !o_out_valid) else $error("spurious result");
endmodule

bind rpn_stack_evaluator rpn_checker u_chk (.*);
